// ----- rtl/srtm_pkg.sv -----
// ----------------------------------------------------------------------------
// srtm_pkg: shared types and functions for the rule table match unit
// Field widths, beat layouts, symmetry decode and neighbourhood permutations.
// ----------------------------------------------------------------------------
package srtm_pkg;

    localparam int MAX_RULES  = 256;
    localparam int IDX_W      = 8;
    localparam int CNT_W      = 9;
    localparam int NUM_CELLS  = 8;
    localparam int POSITIONS  = 9;
    localparam int MASK_BITS  = 5;
    localparam int STATE_W    = 3;
    localparam int MASKS_W    = 45;
    localparam int CELLS_W    = 27;
    localparam int ENTRY_W    = 48;
    localparam int ACT_W      = 2;
    localparam int CFG_W      = 3;
    localparam int S_DATA_W   = 80;
    localparam int M_DATA_W   = 24;

    localparam logic [0:0] CFG_SYM_MODE = 1'b0;
    localparam logic [0:0] CFG_MOORE    = 1'b1;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_LOOKUP = 2'd2
    } srtm_action_t;

    typedef enum logic [2:0] {
        SYM_NONE         = 3'd0,
        SYM_ROT4         = 3'd1,
        SYM_ROT8         = 3'd2,
        SYM_REFLECT      = 3'd3,
        SYM_ROT4_REFLECT = 3'd4,
        SYM_ROT8_REFLECT = 3'd5
    } srtm_sym_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } srtm_state_t;

    typedef logic [3:0] srtm_turns_t;

    typedef struct packed {
        logic        moore;
        logic        step2;
        logic        mirror;
        srtm_turns_t turns;
    } srtm_sym_t;

    typedef struct packed {
        logic               load;
        logic [CELLS_W-1:0] cells;
    } srtm_nb_t;

    typedef struct packed {
        logic               vld;
        logic               last;
        logic [IDX_W-1:0]   idx;
        logic [ENTRY_W-1:0] entry;
        logic               hit;
    } srtm_flit_t;

    function automatic srtm_sym_t srtm_decode(input logic [CFG_W-1:0] mode, input logic moore);
        srtm_sym_t s;
        s.moore  = moore;
        s.step2  = 1'b0;
        s.mirror = 1'b0;
        s.turns  = srtm_turns_t'(1);
        case (srtm_sym_mode_t'(mode))
            SYM_ROT4: begin
                s.turns = srtm_turns_t'(4);
                s.step2 = moore;
            end
            SYM_ROT8: begin
                s.turns = moore ? srtm_turns_t'(8) : srtm_turns_t'(4);
            end
            SYM_REFLECT: begin
                s.mirror = 1'b1;
            end
            SYM_ROT4_REFLECT: begin
                s.turns  = srtm_turns_t'(4);
                s.step2  = moore;
                s.mirror = 1'b1;
            end
            SYM_ROT8_REFLECT: begin
                s.turns  = moore ? srtm_turns_t'(8) : srtm_turns_t'(4);
                s.mirror = 1'b1;
            end
            default: begin
            end
        endcase
        return s;
    endfunction

    // one rotation step around the ring of outer cells
    function automatic logic [CELLS_W-1:0] srtm_rotate(input logic [CELLS_W-1:0] c,
                                                        input logic moore,
                                                        input logic step2);
        logic [CELLS_W-1:0] r;
        r = '0;
        r[STATE_W-1:0] = c[STATE_W-1:0];
        for (int i = 0; i < 8; i++) begin
            if (moore) begin
                if (step2) begin
                    r[STATE_W*(1+i) +: STATE_W] = c[STATE_W*(1+((i+2)&7)) +: STATE_W];
                end else begin
                    r[STATE_W*(1+i) +: STATE_W] = c[STATE_W*(1+((i+1)&7)) +: STATE_W];
                end
            end else if (i < 4) begin
                r[STATE_W*(1+i) +: STATE_W] = c[STATE_W*(1+((i+1)&3)) +: STATE_W];
            end
        end
        return r;
    endfunction

    // east-west reflection
    function automatic logic [CELLS_W-1:0] srtm_mirror(input logic [CELLS_W-1:0] c,
                                                        input logic moore);
        logic [CELLS_W-1:0] r;
        r = c;
        if (moore) begin
            r[STATE_W*2 +: STATE_W] = c[STATE_W*8 +: STATE_W];
            r[STATE_W*8 +: STATE_W] = c[STATE_W*2 +: STATE_W];
            r[STATE_W*3 +: STATE_W] = c[STATE_W*7 +: STATE_W];
            r[STATE_W*7 +: STATE_W] = c[STATE_W*3 +: STATE_W];
            r[STATE_W*4 +: STATE_W] = c[STATE_W*6 +: STATE_W];
            r[STATE_W*6 +: STATE_W] = c[STATE_W*4 +: STATE_W];
        end else begin
            r[STATE_W*2 +: STATE_W] = c[STATE_W*4 +: STATE_W];
            r[STATE_W*4 +: STATE_W] = c[STATE_W*2 +: STATE_W];
        end
        return r;
    endfunction

    function automatic logic srtm_plain(input logic [MASKS_W-1:0] masks,
                                        input logic [CELLS_W-1:0] c,
                                        input logic moore);
        logic         ok;
        logic [7:0]   m;
        logic [STATE_W-1:0] s;
        ok = 1'b1;
        for (int p = 0; p < POSITIONS; p++) begin
            m = {3'b000, masks[MASK_BITS*p +: MASK_BITS]};
            s = c[STATE_W*p +: STATE_W];
            if ((moore || p < 5) && !m[s]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

// ----- rtl/srtm_cell.sv -----
// ----------------------------------------------------------------------------
// srtm_cell: one symmetry cell of the match chain
// Holds one rotation of the neighbourhood, tests each passing rule against it
// and, if mirroring, its reflection, and hands the rule and next rotation on.
// ----------------------------------------------------------------------------
module srtm_cell (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  srtm_pkg::srtm_sym_t    sym,
    input  logic                   en,
    input  srtm_pkg::srtm_nb_t     nb_in,
    input  srtm_pkg::srtm_flit_t   flit_in,
    output srtm_pkg::srtm_nb_t     nb_out,
    output srtm_pkg::srtm_flit_t   flit_out
);

    logic [srtm_pkg::CELLS_W-1:0] nb_reg;
    logic                         load_reg;
    srtm_pkg::srtm_flit_t         flit_reg;
    srtm_pkg::srtm_flit_t         flit_next;
    logic                         match;

    always_comb begin
        match = en && flit_in.vld &&
                (srtm_pkg::srtm_plain(flit_in.entry[srtm_pkg::MASKS_W-1:0], nb_reg, sym.moore) ||
                 (sym.mirror &&
                  srtm_pkg::srtm_plain(flit_in.entry[srtm_pkg::MASKS_W-1:0],
                                       srtm_pkg::srtm_mirror(nb_reg, sym.moore), sym.moore)));
        flit_next     = flit_in;
        flit_next.hit = flit_in.hit | match;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_reg <= 1'b0;
            flit_reg <= '0;
        end else begin
            load_reg <= nb_in.load;
            flit_reg <= flit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (nb_in.load) begin
            nb_reg <= nb_in.cells;
        end
    end

    assign nb_out.load  = load_reg;
    assign nb_out.cells = srtm_pkg::srtm_rotate(nb_reg, sym.moore, sym.step2);
    assign flit_out     = flit_reg;

endmodule

// ----- rtl/symmetric_rule_table_match_unit.sv -----
// ----------------------------------------------------------------------------
// symmetric_rule_table_match_unit: ordered rule table with symmetric lookup
// Clears, appends to, or searches a 256-entry rule table; lookups stream the
// rules through a chain of eight symmetry cells, first hit wins.
// ----------------------------------------------------------------------------
//  channel  | ports               | beat
//  ---------+---------------------+------------------------------------------
//  input    | s_tvalid/s_tready   | tuser: action; tdata: masks, result, cells
//  result   | m_tvalid/m_tready   | tdata: state, matched, index, full, count
//  config   | cfg_we/addr/wdata   | symmetry mode, neighbourhood
//
//  Clear, append, the unused action and a lookup of an empty table have their
//  result registered straight from the beat. Any other lookup has its result
//  registered when its last rule leaves the chain, and no beat is taken before
//  that: the table memory is read one rule per cycle into an eight-cell chain.
//  One item is in work at a time; a waiting result stalls the next input.
//  Reset empties the table; rule memory itself is not cleared.
// ----------------------------------------------------------------------------
module symmetric_rule_table_match_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [srtm_pkg::S_DATA_W-1:0]   s_tdata,   // allowed_sets, rule_result, cells
    input  logic [srtm_pkg::ACT_W-1:0]      s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [srtm_pkg::M_DATA_W-1:0]   m_tdata,   // next_state, matched, rule_index,
                                                       // table_full, rule_count
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_addr,
    input  logic [srtm_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int NC = srtm_pkg::NUM_CELLS;

    logic [srtm_pkg::MASKS_W-1:0]  in_masks;
    logic [srtm_pkg::STATE_W-1:0]  in_result;
    logic [srtm_pkg::CELLS_W-1:0]  in_cells;
    srtm_pkg::srtm_action_t        act;

    assign in_masks  = s_tdata[srtm_pkg::MASKS_W-1:0];
    assign in_result = s_tdata[srtm_pkg::MASKS_W +: srtm_pkg::STATE_W];
    assign in_cells  = s_tdata[srtm_pkg::MASKS_W+srtm_pkg::STATE_W +: srtm_pkg::CELLS_W];
    assign act       = srtm_pkg::srtm_action_t'(s_tuser);

    logic [srtm_pkg::CFG_W-1:0]    sym_mode_reg;
    logic                          moore_reg;
    srtm_pkg::srtm_sym_t           sym;

    srtm_pkg::srtm_state_t         state_reg;
    srtm_pkg::srtm_state_t         state_next;

    logic [srtm_pkg::CNT_W-1:0]    held_reg;
    logic [srtm_pkg::IDX_W-1:0]    ptr_reg;
    logic [srtm_pkg::ENTRY_W-1:0]  rule_mem [0:srtm_pkg::MAX_RULES-1];
    logic [srtm_pkg::ENTRY_W-1:0]  rd_data_reg;
    logic                          iss_vld_reg;
    logic                          iss_last_reg;
    logic [srtm_pkg::IDX_W-1:0]    iss_idx_reg;

    logic [srtm_pkg::STATE_W-1:0]  center_reg;
    logic                          found_reg;
    logic [srtm_pkg::STATE_W-1:0]  hit_state_reg;
    logic [srtm_pkg::IDX_W-1:0]    hit_idx_reg;

    logic                          out_vld_reg;
    logic [srtm_pkg::STATE_W-1:0]  out_state_reg;
    logic                          out_matched_reg;
    logic [srtm_pkg::IDX_W-1:0]    out_idx_reg;
    logic                          out_full_reg;
    logic [srtm_pkg::CNT_W-1:0]    out_count_reg;

    logic                          accept;
    logic                          rd_en;
    logic                          last_issue;
    logic                          table_full;
    logic                          start_walk;
    logic                          take;
    logic                          finish;

    srtm_pkg::srtm_nb_t            nb_chain   [0:NC];
    srtm_pkg::srtm_flit_t          flit_chain [0:NC];
    logic [NC-1:0]                 cell_en;

    assign sym = srtm_pkg::srtm_decode(sym_mode_reg, moore_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_mode_reg <= srtm_pkg::CFG_W'(srtm_pkg::SYM_NONE);
            moore_reg    <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_addr)
                srtm_pkg::CFG_SYM_MODE: sym_mode_reg <= cfg_wdata;
                srtm_pkg::CFG_MOORE:    moore_reg    <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // control
    assign accept     = s_tvalid && s_tready;
    assign table_full = (held_reg == srtm_pkg::CNT_W'(srtm_pkg::MAX_RULES));
    assign start_walk = accept && (act == srtm_pkg::ACT_LOOKUP) && (held_reg != '0);
    assign last_issue = rd_en && ({1'b0, ptr_reg} == srtm_pkg::CNT_W'(held_reg - 1'b1));
    assign finish     = flit_chain[NC].vld && flit_chain[NC].last;
    assign take       = flit_chain[NC].vld && flit_chain[NC].hit && !found_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            srtm_pkg::ST_IDLE: begin
                if (start_walk) state_next = srtm_pkg::ST_ISSUE;
            end
            srtm_pkg::ST_ISSUE: begin
                if (last_issue) state_next = srtm_pkg::ST_DRAIN;
            end
            srtm_pkg::ST_DRAIN: begin
                if (finish) state_next = srtm_pkg::ST_IDLE;
            end
            default: state_next = srtm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        rd_en    = 1'b0;
        case (state_reg)
            srtm_pkg::ST_IDLE:  s_tready = !out_vld_reg || m_tready;
            srtm_pkg::ST_ISSUE: rd_en    = 1'b1;
            srtm_pkg::ST_DRAIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= srtm_pkg::ST_IDLE;
            held_reg    <= '0;
            iss_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            iss_vld_reg <= rd_en;
            if (accept) begin
                case (act)
                    srtm_pkg::ACT_CLEAR:  held_reg <= '0;
                    srtm_pkg::ACT_APPEND: begin
                        if (!table_full) held_reg <= held_reg + 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (start_walk) begin
                found_reg <= 1'b0;
            end else if (take) begin
                found_reg <= 1'b1;
            end
        end
    end

    // table memory: one write port at append, one registered read port for the walk
    always_ff @(posedge aclk) begin
        if (accept && act == srtm_pkg::ACT_APPEND && !table_full) begin
            rule_mem[held_reg[srtm_pkg::IDX_W-1:0]] <= {in_result, in_masks};
        end
        if (rd_en) begin
            rd_data_reg <= rule_mem[ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (start_walk) begin
            ptr_reg    <= '0;
            center_reg <= in_cells[srtm_pkg::STATE_W-1:0];
        end else if (rd_en) begin
            ptr_reg <= ptr_reg + 1'b1;
        end
        iss_last_reg <= last_issue;
        iss_idx_reg  <= ptr_reg;
        if (take) begin
            hit_state_reg <= flit_chain[NC].entry[srtm_pkg::ENTRY_W-1 -: srtm_pkg::STATE_W];
            hit_idx_reg   <= flit_chain[NC].idx;
        end
    end

    // cell chain
    assign nb_chain[0].load    = start_walk;
    assign nb_chain[0].cells   = in_cells;
    assign flit_chain[0].vld   = iss_vld_reg;
    assign flit_chain[0].last  = iss_last_reg;
    assign flit_chain[0].idx   = iss_idx_reg;
    assign flit_chain[0].entry = rd_data_reg;
    assign flit_chain[0].hit   = 1'b0;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        assign cell_en[k] = srtm_pkg::srtm_turns_t'(k) < sym.turns;

        srtm_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .sym      (sym),
            .en       (cell_en[k]),
            .nb_in    (nb_chain[k]),
            .flit_in  (flit_chain[k]),
            .nb_out   (nb_chain[k+1]),
            .flit_out (flit_chain[k+1])
        );
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (accept && !start_walk) begin
            out_vld_reg <= 1'b1;
        end else if (finish) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !start_walk) begin
            out_state_reg   <= '0;
            out_matched_reg <= 1'b0;
            out_idx_reg     <= '0;
            out_full_reg    <= 1'b0;
            out_count_reg   <= held_reg;
            case (act)
                srtm_pkg::ACT_CLEAR:  out_count_reg <= '0;
                srtm_pkg::ACT_APPEND: begin
                    out_full_reg  <= table_full;
                    out_count_reg <= table_full ? held_reg : held_reg + 1'b1;
                end
                srtm_pkg::ACT_LOOKUP: out_state_reg <= in_cells[srtm_pkg::STATE_W-1:0];
                default: begin
                end
            endcase
        end else if (finish) begin
            out_full_reg    <= 1'b0;
            out_count_reg   <= held_reg;
            out_matched_reg <= found_reg || take;
            if (found_reg) begin
                out_state_reg <= hit_state_reg;
                out_idx_reg   <= hit_idx_reg;
            end else if (take) begin
                out_state_reg <= flit_chain[NC].entry[srtm_pkg::ENTRY_W-1 -: srtm_pkg::STATE_W];
                out_idx_reg   <= flit_chain[NC].idx;
            end else begin
                out_state_reg <= center_reg;
                out_idx_reg   <= '0;
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = srtm_pkg::M_DATA_W'({out_count_reg, out_full_reg, out_idx_reg,
                                           out_matched_reg, out_state_reg});

`ifndef SYNTHESIS
    a_last_finds_free_output: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |-> !out_vld_reg)
        else $error("lookup finished while result register occupied");

    a_idle_chain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == srtm_pkg::ST_IDLE) |-> !flit_chain[NC].vld)
        else $error("rule beat left the chain while idle");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == srtm_pkg::ST_ISSUE) |-> ({1'b0, ptr_reg} < held_reg))
        else $error("rule walk past end of table");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= srtm_pkg::CNT_W'(srtm_pkg::MAX_RULES))
        else $error("rule count above table depth");

    a_nb_ahead_of_rules: assert property (@(posedge aclk) disable iff (!aresetn)
        nb_chain[NC].load |-> !flit_chain[NC].vld)
        else $error("neighbourhood load overtaken by rule beat");
`endif

endmodule
